// File: sv/line_length_histogram_defines.svh
// ---------------------------------------------------------------------------
// Line length histogram assertion macros
// Shared concurrent assertion forms; empty when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef LINE_LENGTH_HISTOGRAM_DEFINES_SVH
`define LINE_LENGTH_HISTOGRAM_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LH_ASSERT_IMP(lbl, ante, cons, msg)
`define LH_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/lhist_pkg.sv
// ---------------------------------------------------------------------------
// Line length histogram package
// Shared constants, command codes and the command word type.
// ---------------------------------------------------------------------------
package lhist_pkg;

    localparam int NUM_BINS_DEF    = 1024;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 10;
    localparam int OUT_W   = 32;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [1:0] {
        OP_FEED,
        OP_NEWLINE,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               in_range;
        logic [INDEX_W-1:0] ended_length;
        logic [OUT_W-1:0]   total;
    } cmd_t;

endpackage

// File: sv/lhist_front.sv
// ---------------------------------------------------------------------------
// Line length histogram front end
// Accepts words, tracks the running line length and line total, and
// classifies each word into a command for the bin update stage.
// ---------------------------------------------------------------------------
module lhist_front #(
    parameter int NUM_BINS   = lhist_pkg::NUM_BINS_DEF,
    parameter int COUNT_BITS = lhist_pkg::COUNT_BITS_DEF,
    parameter int BIN_W      = $clog2(NUM_BINS)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic [lhist_pkg::BYTE_W-1:0]  text_byte,
    input  logic [lhist_pkg::INDEX_W-1:0] bin_index,
    input  logic                         queue_full,
    input  logic                         clearing,
    output logic                         push,
    output lhist_pkg::cmd_t              push_cmd,
    output logic [BIN_W-1:0]             push_bin
);
    import lhist_pkg::*;

    localparam int LEN_W = $clog2(NUM_BINS + 1);
    localparam int CMP_W = (BIN_W + 1 > INDEX_W + 1) ? BIN_W + 1 : INDEX_W + 1;
    localparam int CW    = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

    logic [LEN_W-1:0]      len_reg, len_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic                  is_nl;
    logic [BIN_W-1:0]      line_bin;
    logic [CMP_W-1:0]      bin_wide;
    logic [CMP_W-1:0]      idx_wide;
    logic [CW-1:0]         total_wide;

    assign in_stall = queue_full || clearing;
    assign push     = in_valid && !in_stall;
    assign is_nl    = (mode == 1'b0) && (text_byte == NEWLINE_CODE);

    always_comb
    begin
        line_bin = (len_reg == LEN_W'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1)
                                                 : len_reg[BIN_W-1:0];
        bin_wide = CMP_W'(line_bin);
        idx_wide = CMP_W'(bin_index);

        total_next = total_reg;
        len_next   = len_reg;
        if (mode == 1'b0)
        begin
            if (is_nl)
            begin
                total_next = total_reg + 1'b1;
                len_next   = '0;
            end
            else if (len_reg != LEN_W'(NUM_BINS))
            begin
                len_next = len_reg + 1'b1;
            end
        end
        total_wide = CW'(total_next);

        push_cmd.total        = total_wide[OUT_W-1:0];
        push_cmd.in_range     = 1'b0;
        push_cmd.ended_length = '0;
        push_bin              = '0;
        if (mode == 1'b1)
        begin
            push_cmd.op       = OP_READ;
            push_cmd.in_range = (idx_wide < CMP_W'(NUM_BINS));
            push_bin          = idx_wide[BIN_W-1:0];
        end
        else if (is_nl)
        begin
            push_cmd.op           = OP_NEWLINE;
            push_cmd.ended_length = bin_wide[INDEX_W-1:0];
            push_bin              = line_bin;
        end
        else
        begin
            push_cmd.op = OP_FEED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            total_reg <= '0;
        end
        else if (push)
        begin
            len_reg   <= len_next;
            total_reg <= total_next;
        end
    end

endmodule

// File: sv/lhist_fifo.sv
// ---------------------------------------------------------------------------
// Line length histogram command queue
// Small first-in first-out buffer between the front end and the bin stage.
// ---------------------------------------------------------------------------
module lhist_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = lhist_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] head_data,
    output logic              empty,
    output logic              full
);
    import lhist_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/lhist_back.sv
// ---------------------------------------------------------------------------
// Line length histogram bin stage
// Holds the bin memory, clears it after reset, performs read-modify-write
// bin updates with forwarding, and drives the result register.
// ---------------------------------------------------------------------------
`include "line_length_histogram_defines.svh"

module lhist_back #(
    parameter int NUM_BINS   = lhist_pkg::NUM_BINS_DEF,
    parameter int COUNT_BITS = lhist_pkg::COUNT_BITS_DEF,
    parameter int BIN_W      = $clog2(NUM_BINS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  lhist_pkg::cmd_t               head_cmd,
    input  logic [BIN_W-1:0]              head_bin,
    output logic                          pop,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          line_ended,
    output logic [lhist_pkg::INDEX_W-1:0] ended_length,
    output logic [lhist_pkg::OUT_W-1:0]   total_lines,
    output logic [lhist_pkg::OUT_W-1:0]   bin_count
);
    import lhist_pkg::*;

    localparam int CW = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

    logic [COUNT_BITS-1:0] bins_mem [NUM_BINS];

    logic                  clearing_reg;
    logic [BIN_W-1:0]      clr_addr_reg;

    logic                  b_valid_reg;
    cmd_t                  b_cmd_reg;
    logic [BIN_W-1:0]      b_bin_reg;
    logic [COUNT_BITS-1:0] rdata_reg;

    logic                  fwd_valid_reg;
    logic [BIN_W-1:0]      fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic                  out_valid_reg;
    logic                  out_line_ended_reg;
    logic [INDEX_W-1:0]    out_ended_length_reg;
    logic [OUT_W-1:0]      out_total_reg;
    logic [OUT_W-1:0]      out_count_reg;

    logic                  b_fire, b_load, b_write;
    logic [COUNT_BITS-1:0] cur_count, inc_count;
    logic [CW-1:0]         cur_wide;
    logic                  wr_en;
    logic [BIN_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    assign clearing  = clearing_reg;
    assign b_fire    = b_valid_reg && (!out_valid_reg || !out_stall);
    assign b_load    = head_valid && !clearing_reg && (!b_valid_reg || b_fire);
    assign pop       = b_load;
    assign cur_count = (fwd_valid_reg && (fwd_addr_reg == b_bin_reg)) ? fwd_data_reg
                                                                     : rdata_reg;
    assign inc_count = cur_count + 1'b1;
    assign cur_wide  = CW'(cur_count);
    assign b_write   = b_fire && (b_cmd_reg.op == OP_NEWLINE);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = b_bin_reg;
        wr_data = inc_count;
        if (clearing_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else if (b_write)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bins_mem[wr_addr] <= wr_data;
        end
        if (b_load)
        begin
            rdata_reg <= bins_mem[head_bin];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == BIN_W'(NUM_BINS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (b_load)
            begin
                b_valid_reg   <= 1'b1;
                fwd_valid_reg <= b_write;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_cmd_reg    <= head_cmd;
            b_bin_reg    <= head_bin;
            fwd_addr_reg <= b_bin_reg;
            fwd_data_reg <= inc_count;
        end
        if (b_fire)
        begin
            out_line_ended_reg   <= (b_cmd_reg.op == OP_NEWLINE);
            out_ended_length_reg <= b_cmd_reg.ended_length;
            out_total_reg        <= b_cmd_reg.total;
            out_count_reg        <= ((b_cmd_reg.op == OP_READ) && b_cmd_reg.in_range)
                                    ? cur_wide[OUT_W-1:0] : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign line_ended   = out_line_ended_reg;
    assign ended_length = out_ended_length_reg;
    assign total_lines  = out_total_reg;
    assign bin_count    = out_count_reg;

    `LH_ASSERT_IMP(a_no_work_while_clearing, clearing_reg, !b_valid_reg && !pop, "bin stage busy during clear")
    `LH_ASSERT_NXT(a_fwd_after_write, b_load && b_write, fwd_valid_reg, "forward path missed a bin write")
    `LH_ASSERT_IMP(a_newline_no_count, out_valid_reg && out_line_ended_reg, out_count_reg == '0, "newline result carries a bin count")
    `LH_ASSERT_NXT(a_out_hold, out_valid_reg && out_stall, out_valid_reg, "stalled result dropped")

endmodule

// File: sv/line_length_histogram.sv
// ---------------------------------------------------------------------------
// Line length histogram
// Counts line lengths of a byte stream into a bin memory and reads bins.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one word per item. mode 0 feeds
// text_byte; a newline byte closes the current line. mode 1 reads the bin
// selected by bin_index. A word is taken on an edge with in_valid high and
// in_stall low.
// Output channel (out_valid / out_stall): exactly one result word per input
// word, in order, via the command queue, bin stage and result register.
// Throughput is one word per cycle while no stall holds the flow; the bin
// memory is read as a command enters the bin stage and the incremented
// count is written as it leaves, with the last write forwarded to the next
// update. Reset: line length and line total go to zero, then the bin
// memory is cleared one bin per cycle, with in_stall high.
// When the receiver stalls, the result register holds, the command queue
// fills, and in_stall rises once it is full.
// ---------------------------------------------------------------------------
module line_length_histogram #(
    parameter int NUM_BINS    = lhist_pkg::NUM_BINS_DEF,
    parameter int COUNT_BITS  = lhist_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = lhist_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [lhist_pkg::BYTE_W-1:0]  text_byte,
    input  logic [lhist_pkg::INDEX_W-1:0] bin_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          line_ended,
    output logic [lhist_pkg::INDEX_W-1:0] ended_length,
    output logic [lhist_pkg::OUT_W-1:0]   total_lines,
    output logic [lhist_pkg::OUT_W-1:0]   bin_count
);
    import lhist_pkg::*;

    localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int CMD_W = $bits(cmd_t);
    localparam int Q_W   = BIN_W + CMD_W;

    logic             push, pop, queue_empty, queue_full, clearing;
    cmd_t             push_cmd, head_cmd;
    logic [BIN_W-1:0] push_bin, head_bin;
    logic [Q_W-1:0]   head_word;

    lhist_front #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS),
        .BIN_W      (BIN_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .text_byte  (text_byte),
        .bin_index  (bin_index),
        .queue_full (queue_full),
        .clearing   (clearing),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_bin   (push_bin)
    );

    lhist_fifo #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_bin, push_cmd}),
        .pop       (pop),
        .head_data (head_word),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    assign head_bin = head_word[Q_W-1:CMD_W];
    assign head_cmd = head_word[CMD_W-1:0];

    lhist_back #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS),
        .BIN_W      (BIN_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (!queue_empty),
        .head_cmd     (head_cmd),
        .head_bin     (head_bin),
        .pop          (pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_ended   (line_ended),
        .ended_length (ended_length),
        .total_lines  (total_lines),
        .bin_count    (bin_count)
    );

endmodule

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// Line length histogram testbench
// Feeds text bytes and bin reads through the valid/stall input channel,
// predicts every result word from an internal model of the line counter
// and the bin memory, and checks each result field by field. Both sides
// idle at random, and the receiver holds off twice for a long stretch.
// ---------------------------------------------------------------------------
module tb_top;
    import lhist_pkg::*;

    localparam int NUM_BINS = NUM_BINS_DEF;
    localparam int LAST_BIN = NUM_BINS - 1;
    localparam logic MODE_FEED = 1'b0;
    localparam logic MODE_READ = 1'b1;
    localparam int HOLD_CYCLES = 160;
    localparam int MAX_WAIT = 13;

    typedef struct packed {
        logic               mode;
        logic [BYTE_W-1:0]  text_byte;
        logic [INDEX_W-1:0] bin_index;
    } text_word_t;

    typedef struct packed {
        logic               line_ended;
        logic [INDEX_W-1:0] ended_length;
        logic [OUT_W-1:0]   total_lines;
        logic [OUT_W-1:0]   bin_count;
    } hist_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               mode = 1'b0;
    logic [BYTE_W-1:0]  text_byte = '0;
    logic [INDEX_W-1:0] bin_index = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               line_ended;
    logic [INDEX_W-1:0] ended_length;
    logic [OUT_W-1:0]   total_lines;
    logic [OUT_W-1:0]   bin_count;

    text_word_t   pending_words[$];
    hist_result_t expected_results[$];

    logic [INDEX_W:0]   line_len;
    logic [OUT_W-1:0]   lines_total;
    logic [OUT_W-1:0]   bin_counts [NUM_BINS];

    logic word_taken = 1'b0;
    logic result_taken = 1'b0;
    int   results_seen = 0;
    int   mismatch_count = 0;
    int   hold_left = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    bit   send_busy = 1'b1;
    bit   recv_busy = 1'b1;

    line_length_histogram u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .text_byte    (text_byte),
        .bin_index    (bin_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_ended   (line_ended),
        .ended_length (ended_length),
        .total_lines  (total_lines),
        .bin_count    (bin_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic hist_result_t apply_histogram_word(text_word_t w);
        hist_result_t       r;
        logic [INDEX_W-1:0] slot;
        r = '0;
        if (w.mode == MODE_FEED)
        begin
            if (w.text_byte == NEWLINE_CODE)
            begin
                slot = (line_len >= NUM_BINS) ? LAST_BIN[INDEX_W-1:0]
                                              : line_len[INDEX_W-1:0];
                lines_total = lines_total + 1'b1;
                bin_counts[slot] = bin_counts[slot] + 1'b1;
                line_len = '0;
                r.line_ended = 1'b1;
                r.ended_length = slot;
            end
            else if (line_len < NUM_BINS)
            begin
                line_len = line_len + 1'b1;
            end
        end
        else if (w.bin_index < NUM_BINS)
        begin
            r.bin_count = bin_counts[w.bin_index];
        end
        r.total_lines = lines_total;
        return r;
    endfunction

    function automatic int idle_cycles(bit busy);
        return busy ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got,
                                   logic [OUT_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch on %s at result %0d: got %0h, expected %0h",
                     what, results_seen, got, want);
    endtask

    task automatic add_word(logic m, logic [BYTE_W-1:0] b, logic [INDEX_W-1:0] idx);
        text_word_t w;
        w.mode = m;
        w.text_byte = b;
        w.bin_index = idx;
        pending_words.push_back(w);
    endtask

    task automatic add_read(logic [INDEX_W-1:0] idx);
        add_word(MODE_READ, BYTE_W'($urandom), idx);
    endtask

    task automatic add_text(int len, bit close);
        logic [BYTE_W-1:0] b;
        for (int k = 0; k < len; k++)
        begin
            b = BYTE_W'($urandom);
            if (b == NEWLINE_CODE)
                b = b ^ 8'h01;
            add_word(MODE_FEED, b, INDEX_W'($urandom));
            if ($urandom_range(0, 15) == 0)
                add_read(INDEX_W'($urandom_range(0, 15)));
        end
        if (close)
            add_word(MODE_FEED, NEWLINE_CODE, INDEX_W'($urandom));
    endtask

    task automatic add_random_line();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            add_text($urandom_range(0, 12), 1'b1);
        else if (pick < 95)
            add_text($urandom_range(13, 80), 1'b1);
        else
            add_text($urandom_range(81, 200), 1'b1);
    endtask

    // driver: present words from the queue, idle at random between them
    always @(negedge clk)
    begin : driver
        logic       next_valid;
        text_word_t w;
        next_valid = in_valid;
        if (!rst_n)
        begin
            next_valid = 1'b0;
        end
        else
        begin
            if (in_valid && word_taken)
            begin
                next_valid = 1'b0;
                if ($urandom_range(0, 31) == 0)
                    send_busy = !send_busy;
                send_gap = idle_cycles(send_busy);
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_words.size() > 0)
                begin
                    w = pending_words.pop_front();
                    mode <= w.mode;
                    text_byte <= w.text_byte;
                    bin_index <= w.bin_index;
                    next_valid = 1'b1;
                end
            end
        end
        in_valid <= next_valid;
    end

    // receiver: stall at random after a result, plus the long hold-off
    always @(negedge clk)
    begin : receiver
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (result_taken)
            begin
                if ($urandom_range(0, 31) == 0)
                    recv_busy = !recv_busy;
                recv_gap = idle_cycles(recv_busy);
            end
            out_stall <= (recv_gap > 0) || (hold_left != 0);
            if (recv_gap > 0)
                recv_gap--;
        end
    end

    always @(posedge clk)
    begin : hold_off
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (rst_n && out_valid && !out_stall
                 && (results_seen == 150 || results_seen == 400))
            hold_left <= HOLD_CYCLES;
    end

    // monitor: check results, then record the word taken at this edge
    always @(posedge clk)
    begin : monitor
        hist_result_t want;
        if (!rst_n)
        begin
            word_taken <= 1'b0;
            result_taken <= 1'b0;
        end
        else
        begin
            word_taken <= in_valid && !in_stall;
            result_taken <= out_valid && !out_stall;
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with nothing expected", total_lines, '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (line_ended !== want.line_ended)
                        report_mismatch("line_ended", OUT_W'(line_ended),
                                        OUT_W'(want.line_ended));
                    if (ended_length !== want.ended_length)
                        report_mismatch("ended_length", OUT_W'(ended_length),
                                        OUT_W'(want.ended_length));
                    if (total_lines !== want.total_lines)
                        report_mismatch("total_lines", total_lines, want.total_lines);
                    if (bin_count !== want.bin_count)
                        report_mismatch("bin_count", bin_count, want.bin_count);
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(
                    apply_histogram_word({mode, text_byte, bin_index}));
        end
    end

    initial
    begin : stimulus
        int  pick;
        line_len = '0;
        lines_total = '0;
        foreach (bin_counts[k])
            bin_counts[k] = '0;

        add_word(MODE_READ, NEWLINE_CODE, 10'd0);
        add_word(MODE_FEED, NEWLINE_CODE, 10'd0);
        add_word(MODE_FEED, 8'hFF, 10'h3FF);
        add_word(MODE_FEED, 8'h00, 10'h000);
        add_word(MODE_FEED, 8'h09, 10'h155);
        add_word(MODE_FEED, 8'h0B, 10'h2AA);
        add_word(MODE_FEED, NEWLINE_CODE, 10'h3FF);
        add_read(10'd0);
        add_read(10'd4);
        add_word(MODE_READ, 8'hFF, 10'h3FF);
        add_word(MODE_READ, 8'h55, 10'h155);
        add_word(MODE_READ, 8'hAA, 10'h2AA);
        add_word(MODE_FEED, 8'h41, 10'h2AA);
        add_word(MODE_FEED, NEWLINE_CODE, 10'h155);
        add_word(MODE_FEED, NEWLINE_CODE, 10'h000);
        add_read(10'd0);
        add_read(10'd1);

        while (pending_words.size() < 480)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                add_random_line();
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        add_read(INDEX_W'($urandom_range(0, 15)));
                    else if (pick < 9)
                        add_read(INDEX_W'($urandom));
                    else
                        add_read(LAST_BIN[INDEX_W-1:0]);
                end
            end
            else
            begin
                add_text($urandom_range(1, 6), 1'b0);
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS line_length_histogram");
        else
            $display("FAIL line_length_histogram");
        $finish;
    end

    initial
    begin : watchdog
        #3000000;
        $display("FAIL line_length_histogram");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/lhist_pkg.sv
sv/lhist_front.sv
sv/lhist_fifo.sv
sv/lhist_back.sv
sv/line_length_histogram.sv
bench/tb_top.sv
